// ===== rtl/tpm_pkg.sv =====
package tpm_pkg;

  localparam int L1_DEPTH_DEF = 2048;
  localparam int L2_DEPTH_DEF = 1024;

  localparam int ADDR_W   = 24;
  localparam int INDEX_W  = 11;
  localparam int DATA_W   = 32;
  localparam int L1_VAL_W = 5;
  localparam int OFFSET_W = 8;
  localparam int PAGE_W   = 5;

  localparam logic [1:0] ACT_TRANSLATE = 2'd0;
  localparam logic [1:0] ACT_WRITE_L1  = 2'd1;
  localparam logic [1:0] ACT_WRITE_L2  = 2'd2;

  localparam logic [1:0] REGION_MAPPED = 2'd0;
  localparam logic [1:0] REGION_FB     = 2'd1;
  localparam logic [1:0] REGION_COLOR  = 2'd2;
  localparam logic [1:0] REGION_IOPAGE = 2'd3;

  localparam logic [ADDR_W-1:0] REGION_MASK = 24'o77700000;
  localparam logic [ADDR_W-1:0] FB_BASE     = 24'o77000000;
  localparam logic [ADDR_W-1:0] COLOR_BASE  = 24'o77200000;
  localparam logic [ADDR_W-1:0] IOPAGE_MASK = 24'o77777400;
  localparam logic [ADDR_W-1:0] IOPAGE_BASE = 24'o77377400;

  localparam logic [DATA_W-1:0] ACCESS_BITS = 32'h00C0_0000;
  localparam logic [DATA_W-1:0] DEV_WORD    = ACCESS_BITS | 32'o36000;
  localparam logic [DATA_W-1:0] IOPAGE_WORD = ACCESS_BITS | 32'o36777;

  typedef struct packed {
    logic [1:0]         action;
    logic [ADDR_W-1:0]  virt_addr;
    logic [INDEX_W-1:0] map_index;
    logic [DATA_W-1:0]  map_data;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0]   phys_word;
    logic [L1_VAL_W-1:0] first_level;
    logic [OFFSET_W-1:0] page_offset;
    logic [1:0]          region;
  } out_word_t;

endpackage

// ===== rtl/tpm_ram.sv =====
module tpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/two_level_page_map_translate.sv =====
// Two-level page map translator.
// in_data carries one word per item: a translate request or a map entry write.
// out_data returns exactly one word per item, in order: the physical word,
// the first-level value used, the page offset and the region code.
// Writes, device-region translates and the unused action code go straight into
// the output register and may follow each other every cycle while it is free.
// A translate through the maps does one read of the first-level RAM, then one
// read of the second-level RAM, whose address depends on the first read.
// Once rst_n is released, a clearing pass writes zero to every entry of both
// maps, one entry per cycle, walking max(L1_DEPTH, L2_DEPTH) addresses (2048 by
// default); in_ready stays low during reset and until the pass ends.
// The result sits in an output register; a new item is taken while it waits
// as long as it is taken in the same cycle. When the receiver stalls, the
// result holds and in_ready drops; a mapped translate waits in its last step
// with the second-level read data held in the RAM output register.
module two_level_page_map_translate #(
  parameter int L1_DEPTH = tpm_pkg::L1_DEPTH_DEF,
  parameter int L2_DEPTH = tpm_pkg::L2_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tpm_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tpm_pkg::out_word_t out_data
);

  localparam int L1_AW     = $clog2(L1_DEPTH);
  localparam int L2_AW     = $clog2(L2_DEPTH);
  localparam int CLR_DEPTH = (L1_DEPTH > L2_DEPTH) ? L1_DEPTH : L2_DEPTH;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_DEPTH - 1);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_L1    = 4'b0100,
    ST_L2    = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [CLR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  logic [tpm_pkg::OFFSET_W-1:0] off_r, off_nxt;
  logic [tpm_pkg::PAGE_W-1:0]   page_r, page_nxt;
  logic [tpm_pkg::L1_VAL_W-1:0] l1_r, l1_nxt;

  logic               out_valid_r, out_valid_nxt;
  tpm_pkg::out_word_t out_data_r, out_data_nxt;

  logic in_fire, out_free;
  logic is_fb, is_color, is_io, is_xlate, go_lookup;
  logic [tpm_pkg::ADDR_W-1:0] va;

  logic                         l1_we, l1_re;
  logic [L1_AW-1:0]             l1_waddr, l1_raddr;
  logic [tpm_pkg::L1_VAL_W-1:0] l1_wdata, l1_rdata;
  logic                         l2_we, l2_re;
  logic [L2_AW-1:0]             l2_waddr, l2_raddr;
  logic [tpm_pkg::DATA_W-1:0]   l2_wdata, l2_rdata;

  tpm_ram #(
    .WIDTH (tpm_pkg::L1_VAL_W),
    .DEPTH (L1_DEPTH)
  ) u_l1_ram (
    .clk   (clk),
    .we    (l1_we),
    .waddr (l1_waddr),
    .wdata (l1_wdata),
    .re    (l1_re),
    .raddr (l1_raddr),
    .rdata (l1_rdata)
  );

  tpm_ram #(
    .WIDTH (tpm_pkg::DATA_W),
    .DEPTH (L2_DEPTH)
  ) u_l2_ram (
    .clk   (clk),
    .we    (l2_we),
    .waddr (l2_waddr),
    .wdata (l2_wdata),
    .re    (l2_re),
    .raddr (l2_raddr),
    .rdata (l2_rdata)
  );

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;

  assign va        = in_data.virt_addr;
  assign is_fb     = (va & tpm_pkg::REGION_MASK) == tpm_pkg::FB_BASE;
  assign is_color  = (va & tpm_pkg::REGION_MASK) == tpm_pkg::COLOR_BASE;
  assign is_io     = (va & tpm_pkg::IOPAGE_MASK) == tpm_pkg::IOPAGE_BASE;
  assign is_xlate  = in_data.action == tpm_pkg::ACT_TRANSLATE;
  assign go_lookup = in_fire && is_xlate && !is_fb && !is_color && !is_io;

  // Memory ports: the clearing pass owns the write ports until it ends.
  always_comb begin
    if (state_r == ST_CLEAR) begin
      l1_we    = 1'b1;
      l1_waddr = clr_cnt_r[L1_AW-1:0];
      l1_wdata = '0;
      l2_we    = 1'b1;
      l2_waddr = clr_cnt_r[L2_AW-1:0];
      l2_wdata = '0;
    end else begin
      l1_we    = in_fire && (in_data.action == tpm_pkg::ACT_WRITE_L1);
      l1_waddr = L1_AW'(in_data.map_index);
      l1_wdata = in_data.map_data[tpm_pkg::L1_VAL_W-1:0];
      l2_we    = in_fire && (in_data.action == tpm_pkg::ACT_WRITE_L2);
      l2_waddr = in_data.map_index[L2_AW-1:0];
      l2_wdata = in_data.map_data;
    end
  end

  assign l1_re    = go_lookup;
  assign l1_raddr = L1_AW'(va[tpm_pkg::ADDR_W-1:13]);
  assign l2_re    = state_r == ST_L1;
  assign l2_raddr = L2_AW'({l1_rdata, page_r});

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    off_nxt       = off_r;
    page_nxt      = page_r;
    l1_nxt        = l1_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (go_lookup) begin
          off_nxt   = va[tpm_pkg::OFFSET_W-1:0];
          page_nxt  = va[12:8];
          state_nxt = ST_L1;
        end else if (in_fire) begin
          // Writes, device regions and the unused code answer at once.
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          if (is_xlate) begin
            out_data_nxt.page_offset = va[tpm_pkg::OFFSET_W-1:0];
            priority if (is_fb) begin
              out_data_nxt.phys_word = tpm_pkg::DEV_WORD;
              out_data_nxt.region    = tpm_pkg::REGION_FB;
            end else if (is_color) begin
              out_data_nxt.phys_word = tpm_pkg::DEV_WORD;
              out_data_nxt.region    = tpm_pkg::REGION_COLOR;
            end else begin
              out_data_nxt.phys_word = tpm_pkg::IOPAGE_WORD;
              out_data_nxt.region    = tpm_pkg::REGION_IOPAGE;
            end
          end
        end
      end
      ST_L1: begin
        l1_nxt    = l1_rdata;
        state_nxt = ST_L2;
      end
      ST_L2: begin
        // Hold here until the output register frees up.
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.phys_word   = l2_rdata;
          out_data_nxt.first_level = l1_r;
          out_data_nxt.page_offset = off_r;
          out_data_nxt.region      = tpm_pkg::REGION_MAPPED;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt   = ST_CLEAR;
        clr_cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r      <= off_nxt;
    page_r     <= page_nxt;
    l1_r       <= l1_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
